@@ sv/pngunf_pkg.sv @@
// package: shared constants, types and the paeth predictor for the png scanline unfilter
`default_nettype none
package pngunf_pkg;

	localparam int MAX_ROW_BYTES = 16384;
	localparam int ROW_ADDR_W    = $clog2(MAX_ROW_BYTES);
	localparam int COL_W         = 15;
	localparam int ROW_W         = 16;
	localparam int BPP_W         = 3;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_BPP        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT  = 2'd2;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_DATA,
		KIND_ERROR
	} beat_kind_t;

	// per-beat descriptor from the control stage to the reconstruction stage
	typedef struct packed {
		beat_kind_t            kind;
		logic                  clear;
		logic [7:0]            data;
		logic [2:0]            filt;
		logic [ROW_ADDR_W-1:0] idx;
		logic [1:0]            bpp_m1;
		logic                  has_a;
		logic                  first_row;
		logic                  row_end;
		logic                  image_end;
	} beat_t;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		pa = $signed({3'b000, b}) - $signed({3'b000, c});
		pb = $signed({3'b000, a}) - $signed({3'b000, c});
		pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

endpackage
`default_nettype wire

@@ sv/pngunf_if.sv @@
// stream interfaces for the filtered byte input and the reconstructed byte output
`default_nettype none
interface pngunf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       image_start;

	modport source(output valid, output data_byte, output image_start, input ready);
	modport sink(input valid, input data_byte, input image_start, output ready);
endinterface

interface pngunf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       row_end;
	logic       image_end;
	logic       bad_filter;

	modport source(output valid, output pixel_byte, output row_end, output image_end,
		output bad_filter, input ready);
	modport sink(input valid, input pixel_byte, input row_end, input image_end,
		input bad_filter, output ready);
endinterface
`default_nettype wire

@@ sv/png_scanline_unfilter_top.sv @@
// top level of the png scanline unfilter
// data path: an accepted byte goes through the s1 register, then the output register
// one byte per cycle unless stalled; prior-row memory: one read and one write per cycle
// filter bytes give no result; error bytes pass through the same two stages
// reset: arst_n clears counters, flags, byte history and handshake state at once
// the prior-row memory is not cleared and needs no clearing pass
`default_nettype none
module png_scanline_unfilter_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [pngunf_pkg::CFG_INDEX_W-1:0] cfg_addr,
	input  wire logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	pngunf_in_if.sink                               din,
	pngunf_out_if.source                            dout
);

	pngunf_pkg::beat_t                 desc;
	logic                              accept;
	logic                              ready;
	logic                              ram_re;
	logic                              ram_we;
	logic [pngunf_pkg::ROW_ADDR_W-1:0] ram_waddr;
	logic [7:0]                        ram_wdata;
	logic [7:0]                        ram_rdata;

	assign din.ready = ready;
	assign accept    = din.valid && ready;

	pngunf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.data_byte   (din.data_byte),
		.image_start (din.image_start),
		.desc        (desc)
	);

	pngunf_ram #(
		.WIDTH (8),
		.DEPTH (pngunf_pkg::MAX_ROW_BYTES)
	) u_prior_row (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (desc.idx),
		.rdata (ram_rdata)
	);

	pngunf_recon u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (desc),
		.accept     (accept),
		.ready      (ready),
		.ram_re     (ram_re),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.pixel_byte (dout.pixel_byte),
		.row_end    (dout.row_end),
		.image_end  (dout.image_end),
		.bad_filter (dout.bad_filter)
	);

endmodule
`default_nettype wire

@@ sv/pngunf_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none
module pngunf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/pngunf_ctrl.sv @@
// control stage: configuration registers, row and column counters, filter and error state
`default_nettype none
module pngunf_ctrl (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wen,
	input  wire logic [pngunf_pkg::CFG_INDEX_W-1:0]   cfg_addr,
	input  wire logic [pngunf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                                 accept,
	input  wire logic [7:0]                           data_byte,
	input  wire logic                                 image_start,
	output      pngunf_pkg::beat_t                    desc
);

	logic [pngunf_pkg::BPP_W-1:0] bpp_q;
	logic [pngunf_pkg::COL_W-1:0] len_q;
	logic [pngunf_pkg::ROW_W-1:0] cnt_q;

	logic [pngunf_pkg::COL_W-1:0] col_q;
	logic [pngunf_pkg::ROW_W-1:0] row_q;
	logic [2:0]                   filt_q;
	logic                         await_q;
	logic                         err_q;

	logic [1:0]                   bpp_m1;
	logic [pngunf_pkg::COL_W-1:0] last_col;
	logic [pngunf_pkg::ROW_W-1:0] last_row;
	logic [pngunf_pkg::COL_W-1:0] col0;
	logic [pngunf_pkg::ROW_W-1:0] row0;
	logic                         await0;
	logic                         err0;
	logic                         bad;
	logic                         filt_load;
	logic                         err_now;
	logic                         row_end;
	logic                         image_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= pngunf_pkg::BPP_W'(3);
			len_q <= pngunf_pkg::COL_W'(3);
			cnt_q <= pngunf_pkg::ROW_W'(1);
		end else if (cfg_wen) begin
			case (cfg_addr)
				pngunf_pkg::CFG_BPP: begin
					bpp_q <= cfg_wdata[pngunf_pkg::BPP_W-1:0];
				end
				pngunf_pkg::CFG_ROW_LENGTH: begin
					len_q <= cfg_wdata[pngunf_pkg::COL_W-1:0];
				end
				pngunf_pkg::CFG_ROW_COUNT: begin
					cnt_q <= cfg_wdata[pngunf_pkg::ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// effective register values
	always_comb begin
		if (bpp_q == '0) begin
			bpp_m1 = 2'd0;
		end else if (bpp_q > pngunf_pkg::BPP_W'(4)) begin
			bpp_m1 = 2'd3;
		end else begin
			bpp_m1 = 2'(bpp_q - pngunf_pkg::BPP_W'(1));
		end
		if (len_q == '0) begin
			last_col = '0;
		end else if (32'(len_q) > pngunf_pkg::MAX_ROW_BYTES) begin
			last_col = pngunf_pkg::COL_W'(pngunf_pkg::MAX_ROW_BYTES - 1);
		end else begin
			last_col = len_q - pngunf_pkg::COL_W'(1);
		end
		last_row = (cnt_q == '0) ? '0 : cnt_q - pngunf_pkg::ROW_W'(1);
	end

	always_comb begin
		col0      = image_start ? '0 : col_q;
		row0      = image_start ? '0 : row_q;
		await0    = image_start | await_q;
		err0      = image_start ? 1'b0 : err_q;
		bad       = data_byte > 8'(pngunf_pkg::FILT_PAETH);
		filt_load = !err0 && await0 && !bad;
		err_now   = err0 || (await0 && bad);
		row_end   = col0 >= last_col;
		image_end = row_end && (row0 >= last_row);
	end

	always_comb begin
		if (filt_load) begin
			desc.kind = pngunf_pkg::KIND_NONE;
		end else if (err_now) begin
			desc.kind = pngunf_pkg::KIND_ERROR;
		end else begin
			desc.kind = pngunf_pkg::KIND_DATA;
		end
		desc.clear     = image_start | filt_load;
		desc.data      = data_byte;
		desc.filt      = filt_q;
		desc.idx       = (32'(col0) < pngunf_pkg::MAX_ROW_BYTES)
			? pngunf_pkg::ROW_ADDR_W'(col0)
			: pngunf_pkg::ROW_ADDR_W'(pngunf_pkg::MAX_ROW_BYTES - 1);
		desc.bpp_m1    = bpp_m1;
		desc.has_a     = col0 >= (pngunf_pkg::COL_W'(bpp_m1) + pngunf_pkg::COL_W'(1));
		desc.first_row = row0 == '0;
		desc.row_end   = row_end;
		desc.image_end = image_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			filt_q  <= pngunf_pkg::FILT_NONE;
			await_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (filt_load) begin
				filt_q  <= data_byte[2:0];
				await_q <= 1'b0;
				col_q   <= '0;
				row_q   <= row0;
				err_q   <= 1'b0;
			end else if (err_now) begin
				err_q   <= 1'b1;
				col_q   <= col0;
				row_q   <= row0;
				await_q <= await0;
			end else if (row_end) begin
				col_q   <= '0;
				await_q <= 1'b1;
				row_q   <= image_end ? '0 : row0 + pngunf_pkg::ROW_W'(1);
				err_q   <= 1'b0;
			end else begin
				col_q   <= col0 + pngunf_pkg::COL_W'(1);
				row_q   <= row0;
				await_q <= await0;
				err_q   <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/pngunf_recon.sv @@
// reconstruction stage: predictor, prior-row write-back, recent byte history and output register
`default_nettype none
module pngunf_recon (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire pngunf_pkg::beat_t                     desc,
	input  wire logic                                  accept,
	output      logic                                  ready,
	output      logic                                  ram_re,
	output      logic                                  ram_we,
	output      logic [pngunf_pkg::ROW_ADDR_W-1:0]     ram_waddr,
	output      logic [7:0]                            ram_wdata,
	input  wire logic [7:0]                            ram_rdata,
	output      logic                                  out_valid,
	input  wire logic                                  out_ready,
	output      logic [7:0]                            pixel_byte,
	output      logic                                  row_end,
	output      logic                                  image_end,
	output      logic                                  bad_filter
);

	logic                              vld_s1;
	logic                              err_s1;
	logic [7:0]                        x_s1;
	logic [2:0]                        filt_s1;
	logic [pngunf_pkg::ROW_ADDR_W-1:0] idx_s1;
	logic [1:0]                        bpp_m1_s1;
	logic                              has_a_s1;
	logic                              first_row_s1;
	logic                              row_end_s1;
	logic                              image_end_s1;
	logic                              fwd_s1;
	logic [7:0]                        fwd_data_s1;

	logic [7:0] rr_q [4];
	logic [7:0] ra_q [4];

	logic       out_vld_q;
	logic       advance;
	logic       load_s1;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] ab_sum;
	logic [7:0] pred;
	logic [7:0] recon;

	assign advance = !out_vld_q || out_ready;
	assign ready   = !vld_s1 || advance;
	assign load_s1 = accept && (desc.kind != pngunf_pkg::KIND_NONE);
	assign ram_re  = accept && (desc.kind == pngunf_pkg::KIND_DATA);

	always_comb begin
		b      = first_row_s1 ? 8'd0 : (fwd_s1 ? fwd_data_s1 : ram_rdata);
		a      = has_a_s1 ? rr_q[bpp_m1_s1] : 8'd0;
		c      = (has_a_s1 && !first_row_s1) ? ra_q[bpp_m1_s1] : 8'd0;
		ab_sum = {1'b0, a} + {1'b0, b};
		case (filt_s1)
			pngunf_pkg::FILT_SUB:   pred = a;
			pngunf_pkg::FILT_UP:    pred = b;
			pngunf_pkg::FILT_AVG:   pred = ab_sum[8:1];
			pngunf_pkg::FILT_PAETH: pred = pngunf_pkg::paeth_pick(a, b, c);
			default:                pred = 8'd0;
		endcase
		recon = x_s1 + pred;
	end

	assign ram_we    = vld_s1 && !err_s1 && advance;
	assign ram_waddr = idx_s1;
	assign ram_wdata = recon;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready) begin
			vld_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			err_s1       <= desc.kind == pngunf_pkg::KIND_ERROR;
			x_s1         <= desc.data;
			filt_s1      <= desc.filt;
			idx_s1       <= desc.idx;
			bpp_m1_s1    <= desc.bpp_m1;
			has_a_s1     <= desc.has_a;
			first_row_s1 <= desc.first_row;
			row_end_s1   <= desc.row_end;
			image_end_s1 <= desc.image_end;
			// same entry written this edge: the memory returns the old byte
			fwd_s1       <= ram_we && (idx_s1 == desc.idx);
			fwd_data_s1  <= recon;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				rr_q[k] <= 8'd0;
				ra_q[k] <= 8'd0;
			end
		end else if (accept && desc.clear) begin
			for (int k = 0; k < 4; k++) begin
				rr_q[k] <= 8'd0;
				ra_q[k] <= 8'd0;
			end
		end else if (ram_we) begin
			for (int k = 3; k > 0; k--) begin
				rr_q[k] <= rr_q[k-1];
				ra_q[k] <= ra_q[k-1];
			end
			rr_q[0] <= recon;
			ra_q[0] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			pixel_byte <= err_s1 ? 8'd0 : recon;
			row_end    <= err_s1 ? 1'b0 : row_end_s1;
			image_end  <= err_s1 ? 1'b0 : image_end_s1;
			bad_filter <= err_s1;
		end
	end

	assign out_valid = out_vld_q;

endmodule
`default_nettype wire

@@ sv/pngunf_checker.sv @@
// port-level checker for the png scanline unfilter and its bind
`default_nettype none
module pngunf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] pixel_byte,
	input wire logic       row_end,
	input wire logic       image_end,
	input wire logic       bad_filter
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_byte) && $stable(row_end)
			&& $stable(image_end) && $stable(bad_filter))
		else $error("output beat changed while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_filter |-> pixel_byte == 8'd0 && !row_end && !image_end)
		else $error("error beat carries data or row marks");

	a_image_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

endmodule

bind png_scanline_unfilter_top pngunf_checker u_pngunf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.pixel_byte (dout.pixel_byte),
	.row_end    (dout.row_end),
	.image_end  (dout.image_end),
	.bad_filter (dout.bad_filter)
);
`default_nettype wire

@@ verif/png_scanline_unfilter_top_test.sv @@
// png_scanline_unfilter_top testbench: directed and random byte streams checked beat by beat
module png_scanline_unfilter_top_test;
	import pngunf_pkg::*;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       row_end;
		logic       image_end;
		logic       bad_filter;
	} pix_t;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
		bit         pinned;
		bit         pin_has;
		pix_t       pin;
	} probe_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_BEATS = 100;
	localparam int DRAIN_CYCLES = 4;
	localparam int DIRECTED_RETUNE_AT = 6;
	localparam int REPORT_LIMIT = 50;
	localparam logic [7:0] FILT_BAD_MIN = {5'd0, FILT_PAETH} + 8'd1;
	localparam pix_t NO_PIX = '0;
	localparam pix_t BAD_PIX = '{8'h00, 1'b0, 1'b0, 1'b1};

	localparam probe_t DIRECTED [26] = '{
		'{1'b1, {5'd0, FILT_NONE}, 1'b1, 1'b0, NO_PIX},
		'{1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{1'b0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
		'{1'b0, 8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0}},
		'{1'b0, FILT_BAD_MIN, 1'b1, 1'b1, BAD_PIX},
		'{1'b0, 8'hFF, 1'b1, 1'b1, BAD_PIX},
		'{1'b1, {5'd0, FILT_SUB}, 1'b1, 1'b0, NO_PIX},
		'{1'b0, 8'h10, 1'b1, 1'b1, '{8'h10, 1'b0, 1'b0, 1'b0}},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h01, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'hF8, 1'b0, 1'b0, NO_PIX},
		'{1'b0, {5'd0, FILT_UP}, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'hF0, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h01, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h80, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_PIX},
		'{1'b0, {5'd0, FILT_AVG}, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h02, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h7F, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h81, 1'b0, 1'b0, NO_PIX},
		'{1'b0, {5'd0, FILT_PAETH}, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'h10, 1'b0, 1'b0, NO_PIX},
		'{1'b0, 8'hEF, 1'b0, 1'b0, NO_PIX}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pngunf_in_if din_bus();
	pngunf_out_if dout_bus();

	png_scanline_unfilter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.din(din_bus),
		.dout(dout_bus)
	);

	// behavioral unfilter state
	logic [7:0] prior_row [MAX_ROW_BYTES];
	logic [7:0] left_hist [4];
	logic [7:0] up_hist [4];
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned store_fill;
	logic [2:0] cur_filt;
	bit want_filter;
	bit err_seen;
	logic [2:0] bpp_reg;
	logic [14:0] len_reg;
	logic [15:0] cnt_reg;

	pix_t expected_pixels [$];
	pix_t last_pix;
	bit last_has;
	int mismatches = 0;
	int cycles = 0;
	int beats_sent = 0;
	int src_gap_pct = 0;
	int snk_stall_pct = 0;
	int stall_left = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("png_scanline_unfilter_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			dout_bus.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < snk_stall_pct) begin
			dout_bus.ready <= 1'b0;
			stall_left <= $urandom_range(3);
		end else begin
			dout_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		pix_t got;
		pix_t want;
		got = '{dout_bus.pixel_byte, dout_bus.row_end, dout_bus.image_end, dout_bus.bad_filter};
		if (arst_n === 1'b1 && dout_bus.valid === 1'b1 && dout_bus.ready === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: expected no beat, got byte %h row_end %b image_end %b",
						$time, got.pixel_byte, got.row_end, got.image_end,
						" bad_filter %b", got.bad_filter);
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: expected byte %h row_end %b image_end %b bad_filter %b,",
							$time, want.pixel_byte, want.row_end, want.image_end,
							want.bad_filter, " got byte %h row_end %b image_end %b bad_filter %b",
							got.pixel_byte, got.row_end, got.image_end, got.bad_filter);
				end
			end
		end
	end

	function automatic void clear_history();
		foreach (left_hist[k]) begin
			left_hist[k] = 8'h00;
			up_hist[k] = 8'h00;
		end
	endfunction

	function automatic logic [7:0] paeth_guess(input int a, input int b, input int c);
		int da;
		int db;
		int dc;
		da = (b > c) ? b - c : c - b;
		db = (a > c) ? a - c : c - a;
		dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
		if (da <= db && da <= dc)
			return a[7:0];
		return (db <= dc) ? b[7:0] : c[7:0];
	endfunction

	function automatic bit unfilter_byte(input logic [7:0] x, input logic start, output pix_t r);
		int bpp;
		int len;
		int cnt;
		int a;
		int b;
		int c;
		int pred;
		logic [7:0] recon;
		bit top_row;
		bit last_col;
		bit last_row;
		r = '0;
		if (start) begin
			col_pos = 0;
			row_pos = 0;
			want_filter = 1'b1;
			err_seen = 1'b0;
			clear_history();
		end
		if (!err_seen && want_filter) begin
			if (x > {5'd0, FILT_PAETH}) begin
				err_seen = 1'b1;
			end else begin
				cur_filt = x[2:0];
				want_filter = 1'b0;
				col_pos = 0;
				clear_history();
				return 1'b0;
			end
		end
		if (err_seen) begin
			r.bad_filter = 1'b1;
			return 1'b1;
		end
		bpp = (bpp_reg == 0) ? 1 : (bpp_reg > 4) ? 4 : bpp_reg;
		len = (len_reg == 0) ? 1 : (len_reg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : len_reg;
		cnt = (cnt_reg == 0) ? 1 : cnt_reg;
		top_row = (row_pos == 0);
		b = top_row ? 0 : prior_row[col_pos];
		a = (col_pos >= bpp) ? left_hist[bpp-1] : 0;
		c = (col_pos >= bpp && !top_row) ? up_hist[bpp-1] : 0;
		case (cur_filt)
			FILT_SUB: pred = a;
			FILT_UP: pred = b;
			FILT_AVG: pred = (a + b) / 2;
			FILT_PAETH: pred = paeth_guess(a, b, c);
			default: pred = 0;
		endcase
		recon = x + pred[7:0];
		for (int k = 3; k > 0; k--) begin
			left_hist[k] = left_hist[k-1];
			up_hist[k] = up_hist[k-1];
		end
		left_hist[0] = recon;
		up_hist[0] = b[7:0];
		prior_row[col_pos] = recon;
		if (col_pos + 1 > store_fill)
			store_fill = col_pos + 1;
		last_col = (col_pos >= len - 1);
		last_row = last_col && (row_pos >= cnt - 1);
		if (last_col) begin
			col_pos = 0;
			want_filter = 1'b1;
			row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
		end else begin
			col_pos = col_pos + 1;
		end
		r.pixel_byte = recon;
		r.row_end = last_col;
		r.image_end = last_row;
		return 1'b1;
	endfunction

	function automatic logic [7:0] next_filter();
		if ($urandom_range(99) < 4)
			return 8'($urandom_range(FILT_BAD_MIN, 255));
		return {5'd0, 3'($urandom_range(FILT_NONE, FILT_PAETH))};
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic s, input bit pinned,
		input bit pin_has, input pix_t pin);
		pix_t pix;
		bit has;
		if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			din_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.data_byte <= b;
		din_bus.image_start <= s;
		do @(posedge clk); while (din_bus.ready !== 1'b1);
		has = unfilter_byte(b, s, pix);
		if (pinned) begin
			has = pin_has;
			pix = pin;
		end
		if (has)
			expected_pixels.insert(expected_pixels.size(), pix);
		last_has = has;
		last_pix = pix;
		beats_sent++;
	endtask

	task automatic apply_config(input logic [2:0] b, input logic [14:0] l, input logic [15:0] c);
		din_bus.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		// a trailing filter byte may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= CFG_BPP;
		cfg_wdata <= {13'($urandom), b};
		@(posedge clk);
		cfg_addr <= CFG_ROW_LENGTH;
		cfg_wdata <= {1'($urandom), l};
		@(posedge clk);
		cfg_addr <= CFG_ROW_COUNT;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_wen <= 1'b0;
		bpp_reg = b;
		len_reg = l;
		cnt_reg = c;
	endtask

	task automatic run_image();
		int cap;
		int retune_at;
		int room;
		int sent;
		cap = (len_reg + 2) * 6;
		if (cap > 160)
			cap = 160;
		retune_at = ($urandom_range(7) == 0) ? $urandom_range(1, cap - 1) : 0;
		send_byte(next_filter(), 1'b1, 1'b0, 1'b0, NO_PIX);
		for (sent = 1; sent < cap; sent++) begin
			if (err_seen && $urandom_range(2) == 0)
				break;
			if (last_has && last_pix.image_end && $urandom_range(3) != 0)
				break;
			if ($urandom_range(199) == 0)
				break;
			if (sent == retune_at && !want_filter && !err_seen) begin
				// past the first row only columns already stored may be read
				room = (row_pos == 0) ? 24 : (store_fill < 24 ? store_fill : 24);
				apply_config(3'($urandom), 15'($urandom_range(0, room)),
					16'($urandom_range(0, 5)));
			end
			send_byte(want_filter ? next_filter() : 8'($urandom), 1'b0, 1'b0, 1'b0, NO_PIX);
		end
	endtask

	initial begin
		int phase;
		int phase_start;
		int pick;
		bit calm;
		logic [14:0] len_v;
		logic [15:0] cnt_v;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = CFG_BPP;
		cfg_wdata = '0;
		din_bus.valid = 1'b0;
		din_bus.data_byte = 8'h00;
		din_bus.image_start = 1'b0;
		dout_bus.ready = 1'b0;
		clear_history();
		col_pos = 0;
		row_pos = 0;
		store_fill = 0;
		cur_filt = FILT_NONE;
		want_filter = 1'b1;
		err_seen = 1'b0;
		bpp_reg = 3'd3;
		len_reg = 15'd3;
		cnt_reg = 16'd1;
		last_has = 1'b0;
		last_pix = NO_PIX;
		src_gap_pct = 20;
		snk_stall_pct = 20;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (i == DIRECTED_RETUNE_AT)
				apply_config(3'd3, 15'd4, 16'd4);
			send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].pinned,
				DIRECTED[i].pin_has, DIRECTED[i].pin);
		end

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			calm = (phase >= RANDOM_PHASES - 2);
			src_gap_pct = calm ? 0 : $urandom_range(0, 3) * 10;
			snk_stall_pct = calm ? 0 : $urandom_range(0, 3) * 10;
			if (phase == RANDOM_PHASES - 3) begin
				// row length and bytes per pixel above their limits, start of a long row
				src_gap_pct = 0;
				snk_stall_pct = 0;
				apply_config(3'd7, 15'h7FFF, 16'd2);
				phase_start = beats_sent;
				send_byte({5'd0, FILT_PAETH}, 1'b1, 1'b0, 1'b0, NO_PIX);
				while (beats_sent - phase_start < PHASE_BEATS)
					send_byte(want_filter ? {5'd0, 3'($urandom_range(FILT_NONE, FILT_PAETH))}
						: 8'($urandom), 1'b0, 1'b0, 1'b0, NO_PIX);
			end else begin
				pick = $urandom_range(9);
				len_v = (pick < 2) ? 15'($urandom_range(0, 4)) : 15'($urandom_range(3, 24));
				pick = $urandom_range(9);
				cnt_v = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 5));
				if (phase == 0) begin
					len_v = 15'd0;
					cnt_v = 16'd0;
				end
				if (phase == 1)
					cnt_v = 16'hFFFF;
				apply_config((phase < 8) ? 3'(phase) : 3'($urandom_range(3, 4)), len_v, cnt_v);
				phase_start = beats_sent;
				while (beats_sent - phase_start < PHASE_BEATS)
					run_image();
			end
		end

		din_bus.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (mismatches == 0)
			$display("png_scanline_unfilter_top: match");
		else
			$display("png_scanline_unfilter_top: mismatch");
		$finish;
	end

endmodule
